### rtl/pvtd_pkg.sv
package pvtd_pkg;

  // Store and coordinate sizes
  localparam int MAX_BLOCKS = 4096;
  localparam int IDX_BITS   = $clog2(MAX_BLOCKS);
  localparam int COORD_BITS = 10;
  localparam int BLK_BITS   = COORD_BITS - 2;

  // Request codes
  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_FETCH = 1'b1;

  // Configuration register indexes
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 4;
  localparam logic [CFG_IDX_W-1:0] CFG_TWO_BIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WRAP    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT  = 2'd3;

  // Block modulation modes as stored per block
  localparam logic [1:0] MODE_PLAIN = 2'd0;
  localparam logic [1:0] MODE_AVG4  = 2'd1;
  localparam logic [1:0] MODE_HORIZ = 2'd2;
  localparam logic [1:0] MODE_VERT  = 2'd3;

  // Per-word control that travels down the pipeline
  typedef struct packed {
    logic       vld;
    logic       fault;
    logic       two;
    logic [2:0] xl;
    logic [1:0] yl;
  } pvtd_ctl_t;

  // Unpacked endpoint colour, 5554 at most
  typedef struct packed {
    logic [4:0] r;
    logic [4:0] g;
    logic [4:0] b;
    logic [3:0] a;
  } pvtd_col_t;

  function automatic logic [3:0] rep_plain(input logic [1:0] m);
    logic [3:0] v;
    case (m)
      2'd0: v = 4'd0;
      2'd1: v = 4'd3;
      2'd2: v = 4'd5;
      default: v = 4'd8;
    endcase
    return v;
  endfunction

  function automatic logic [3:0] rep_punch(input logic [1:0] m);
    logic [3:0] v;
    case (m)
      2'd0: v = 4'd0;
      2'd1: v = 4'd4;
      2'd2: v = 4'd4;
      default: v = 4'd8;
    endcase
    return v;
  endfunction

endpackage

### rtl/pvtd_addr.sv
module pvtd_addr
  import pvtd_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         fetch,
  input  logic [COORD_BITS-1:0]        texel_x,
  input  logic [COORD_BITS-1:0]        texel_y,
  input  logic                         two_bit_mode,
  input  logic                         wrap_edges,
  input  logic [3:0]                   width_log2,
  input  logic [3:0]                   height_log2,
  output logic [3:0][IDX_BITS-1:0]     idx,
  output pvtd_ctl_t                    ctl
);

  localparam int CW = COORD_BITS + 1;

  // Morton interleave: y bits at even positions, x bits at odd, rest of the
  // larger dimension above
  function automatic logic [IDX_BITS-1:0] twiddle(input logic [3:0] lh,
                                                  input logic [3:0] lw,
                                                  input logic [BLK_BITS-1:0] by,
                                                  input logic [BLK_BITS-1:0] bx);
    logic [3:0]            sc;
    logic [BLK_BITS-1:0]   big;
    logic [2*BLK_BITS-1:0] t;
    sc  = (lh < lw) ? lh : lw;
    big = (lh < lw) ? bx : by;
    t   = '0;
    for (int i = 0; i < BLK_BITS; i++) begin
      if (4'(i) < sc) begin
        t[2*i]   = by[i];
        t[2*i+1] = bx[i];
      end
    end
    t = t | (((2*BLK_BITS)'(big) >> sc) << {sc, 1'b0});
    return t[IDX_BITS-1:0];
  endfunction

  logic [3:0]          wl, hl, xsl, bwl, bhl;
  logic [CW-1:0]       wpow, hpow, wmask, hmask, half, xe, ye, bxf, byf;
  logic [BLK_BITS-1:0] bx, by, bx1, by1;
  logic [BLK_BITS:0]   bwm1, bhm1, bxp, byp;
  logic                fault;

  // Size decode and range check
  always_comb begin
    wl    = (width_log2 < 4'd3) ? 4'd3 :
            ((width_log2 > 4'(COORD_BITS)) ? 4'(COORD_BITS) : width_log2);
    hl    = (height_log2 < 4'd2) ? 4'd2 :
            ((height_log2 > 4'(COORD_BITS)) ? 4'(COORD_BITS) : height_log2);
    xsl   = two_bit_mode ? 4'd3 : 4'd2;
    bwl   = (wl > xsl + 4'd1) ? wl - xsl : 4'd1;
    bhl   = (hl > 4'd3) ? hl - 4'd2 : 4'd1;
    wpow  = CW'(1) << wl;
    hpow  = CW'(1) << hl;
    wmask = wpow - CW'(1);
    hmask = hpow - CW'(1);
    xe    = CW'(texel_x);
    ye    = CW'(texel_y);
    fault = ((xe >> wl) != '0) || ((ye >> hl) != '0);
    half  = two_bit_mode ? CW'(4) : CW'(2);
  end

  // Top-left neighbour block and its right / lower partners
  always_comb begin
    if (wrap_edges) begin
      bxf = (xe + wpow - half) & wmask;
      byf = (ye + hpow - CW'(2)) & hmask;
    end else begin
      bxf = (xe < half) ? '0 : xe - half;
      byf = (ye < CW'(2)) ? '0 : ye - CW'(2);
    end
    bx   = BLK_BITS'(bxf >> xsl);
    by   = BLK_BITS'(byf >> 2);
    bwm1 = ((BLK_BITS+1)'(1) << bwl) - (BLK_BITS+1)'(1);
    bhm1 = ((BLK_BITS+1)'(1) << bhl) - (BLK_BITS+1)'(1);
    bxp  = (BLK_BITS+1)'(bx) + (BLK_BITS+1)'(1);
    byp  = (BLK_BITS+1)'(by) + (BLK_BITS+1)'(1);
    if (wrap_edges) begin
      bx1 = BLK_BITS'(bxp & bwm1);
      by1 = BLK_BITS'(byp & bhm1);
    end else begin
      bx1 = (bxp <= bwm1) ? BLK_BITS'(bxp) : BLK_BITS'(bwm1);
      by1 = (byp <= bhm1) ? BLK_BITS'(byp) : BLK_BITS'(bhm1);
    end
  end

  always_ff @(posedge clk) begin
    idx[0] <= twiddle(bhl, bwl, by,  bx);
    idx[1] <= twiddle(bhl, bwl, by,  bx1);
    idx[2] <= twiddle(bhl, bwl, by1, bx);
    idx[3] <= twiddle(bhl, bwl, by1, bx1);
    ctl.fault <= fault;
    ctl.two   <= two_bit_mode;
    ctl.xl    <= texel_x[2:0];
    ctl.yl    <= texel_y[1:0];
    if (rst) begin
      ctl.vld <= 1'b0;
    end else begin
      ctl.vld <= fetch;
    end
  end

endmodule

### rtl/pvtd_store.sv
module pvtd_store
  import pvtd_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     we,
  input  logic [IDX_BITS-1:0]      waddr,
  input  logic [63:0]              wdata,
  input  logic [3:0][IDX_BITS-1:0] raddr,
  input  pvtd_ctl_t                ctl_in,
  output logic [3:0][63:0]         rdata,
  output pvtd_ctl_t                ctl
);

  // Four copies of the block store, one read port each
  logic [63:0] mem [4][MAX_BLOCKS];

  always_ff @(posedge clk) begin
    for (int k = 0; k < 4; k++) begin
      if (we) begin
        mem[k][waddr] <= wdata;
      end
      rdata[k] <= mem[k][raddr[k]];
    end
  end

  always_ff @(posedge clk) begin
    ctl.fault <= ctl_in.fault;
    ctl.two   <= ctl_in.two;
    ctl.xl    <= ctl_in.xl;
    ctl.yl    <= ctl_in.yl;
    if (rst) begin
      ctl.vld <= 1'b0;
    end else begin
      ctl.vld <= ctl_in.vld;
    end
  end

endmodule

### rtl/pvtd_unpack.sv
module pvtd_unpack
  import pvtd_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic [3:0][63:0]  words,
  input  pvtd_ctl_t         ctl_in,
  output pvtd_col_t [3:0]   col_a,
  output pvtd_col_t [3:0]   col_b,
  output logic [3:0]        mv,
  output logic              pt,
  output pvtd_ctl_t         ctl
);

  function automatic pvtd_col_t unpack_col(input logic [15:0] raw, input logic is_b);
    pvtd_col_t  c;
    logic [4:0] t;
    if (raw[15]) begin
      c.r = raw[14:10];
      c.g = raw[9:5];
      c.b = raw[4:0];
      if (!is_b) c.b = c.b | (c.b >> 4);
      c.a = 4'hF;
    end else begin
      c.r = {raw[11:8], raw[11]};
      c.g = {raw[7:4], raw[7]};
      t   = {raw[3:0], 1'b0};
      c.b = is_b ? (t | (t >> 4)) : (t | (t >> 3));
      c.a = {raw[14:12], 1'b0};
    end
    return c;
  endfunction

  // Modulation code and block mode at grid row r, column c of the 2x2 blocks
  function automatic logic [3:0] mod_at(input logic [3:0][63:0] w, input logic two,
                                        input logic [2:0] r, input logic [3:0] c);
    logic [63:0] wd;
    logic [31:0] bits;
    logic [1:0]  bm, md;
    logic [1:0]  ly;
    logic [2:0]  lx;
    logic [4:0]  n;
    logic        j;
    j    = two ? c[3] : c[2];
    wd   = w[{r[2], j}];
    bits = wd[31:0];
    bm   = {1'b0, wd[32]};
    ly   = r[1:0];
    lx   = two ? c[2:0] : {1'b0, c[1:0]};
    md   = 2'd0;
    if (two && wd[32]) begin
      if (bits[0]) begin
        bm       = bits[20] ? MODE_VERT : MODE_HORIZ;
        bits[20] = bits[21];
      end
      bits[0] = bits[1];
      n = {1'b0, ly, lx[2:1]};
      if ((lx[0] ^ ly[0]) == 1'b0) md = bits[{n[3:0], 1'b0} +: 2];
    end else if (two) begin
      n  = {ly, lx};
      md = bits[n] ? 2'd3 : 2'd0;
    end else begin
      n  = {1'b0, ly, lx[1:0]};
      md = bits[{n[3:0], 1'b0} +: 2];
    end
    return {bm, md};
  endfunction

  logic [2:0] my;
  logic [3:0] mx;
  logic [3:0] mc, mu, mdn, ml, mr;
  logic [3:0] mv_next;
  logic [5:0] sum4;
  logic [4:0] sum_h, sum_v;
  logic       pt_next;

  // Modulation weight selection
  always_comb begin
    my    = {~ctl_in.yl[1], ctl_in.yl};
    mx    = ctl_in.two ? {~ctl_in.xl[2], ctl_in.xl}
                       : {1'b0, ~ctl_in.xl[1], ctl_in.xl[1:0]};
    mc    = mod_at(words, ctl_in.two, my, mx);
    mu    = mod_at(words, ctl_in.two, my - 3'd1, mx);
    mdn   = mod_at(words, ctl_in.two, my + 3'd1, mx);
    ml    = mod_at(words, ctl_in.two, my, mx - 4'd1);
    mr    = mod_at(words, ctl_in.two, my, mx + 4'd1);
    sum4  = 6'(rep_plain(mu[1:0])) + 6'(rep_plain(mdn[1:0])) +
            6'(rep_plain(ml[1:0])) + 6'(rep_plain(mr[1:0])) + 6'd2;
    sum_h = 5'(rep_plain(ml[1:0])) + 5'(rep_plain(mr[1:0])) + 5'd1;
    sum_v = 5'(rep_plain(mu[1:0])) + 5'(rep_plain(mdn[1:0])) + 5'd1;
    pt_next = 1'b0;
    if (mc[3:2] == MODE_PLAIN) begin
      mv_next = rep_plain(mc[1:0]);
    end else if (ctl_in.two) begin
      if ((mx[0] ^ my[0]) == 1'b0)    mv_next = rep_plain(mc[1:0]);
      else if (mc[3:2] == MODE_AVG4)  mv_next = 4'(sum4 >> 2);
      else if (mc[3:2] == MODE_HORIZ) mv_next = 4'(sum_h >> 1);
      else                            mv_next = 4'(sum_v >> 1);
    end else begin
      mv_next = rep_punch(mc[1:0]);
      pt_next = (mc[1:0] == 2'd2);
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 4; k++) begin
      col_a[k] <= unpack_col(words[k][47:32] & 16'hFFFE, 1'b0);
      col_b[k] <= unpack_col(words[k][63:48], 1'b1);
    end
    mv  <= mv_next;
    pt  <= pt_next;
    ctl.fault <= ctl_in.fault;
    ctl.two   <= ctl_in.two;
    ctl.xl    <= ctl_in.xl;
    ctl.yl    <= ctl_in.yl;
    if (rst) begin
      ctl.vld <= 1'b0;
    end else begin
      ctl.vld <= ctl_in.vld;
    end
  end

endmodule

### rtl/pvtd_filter.sv
module pvtd_filter
  import pvtd_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  pvtd_col_t [3:0]  col_a,
  input  pvtd_col_t [3:0]  col_b,
  input  logic [3:0]       mv,
  input  logic             pt,
  input  pvtd_ctl_t        ctl_in,
  output logic             done,
  output logic [7:0]       red,
  output logic [7:0]       green,
  output logic [7:0]       blue,
  output logic [7:0]       alpha,
  output logic             coord_fault
);

  // Horizontal step: p*us + u*(q-p)
  function automatic logic signed [11:0] lerp_h(input logic [4:0] p, input logic [4:0] q,
                                                input logic two, input logic [2:0] u);
    logic signed [11:0] ps, qs, uu;
    ps = $signed({7'b0, p});
    qs = $signed({7'b0, q});
    uu = $signed({9'b0, u});
    return (two ? (ps <<< 3) : (ps <<< 2)) + uu * (qs - ps);
  endfunction

  // Vertical step, clamp and expansion to 8 bits
  function automatic logic [7:0] lerp_v(input logic signed [11:0] t1,
                                        input logic signed [11:0] t2,
                                        input logic [1:0] v, input logic two,
                                        input logic is_a);
    logic signed [11:0] t, vv;
    logic [9:0]         o;
    vv = $signed({10'b0, v});
    t  = (t1 <<< 2) + vv * (t2 - t1);
    if (t < 0) t = '0;
    if (is_a) begin
      o = two ? 10'(t[10:1]) : t[9:0];
      o = o + (o >> 4);
    end else begin
      o = two ? 10'(t[11:2]) : t[10:1];
      o = o + (o >> 5);
    end
    return o[7:0];
  endfunction

  // Blend of the two colours by weight m in eighths
  function automatic logic [7:0] blend(input logic [7:0] a, input logic [7:0] b,
                                       input logic [3:0] m);
    logic signed [12:0] as, bs, ms, r;
    as = $signed({5'b0, a});
    bs = $signed({5'b0, b});
    ms = $signed({9'b0, m});
    r  = (as <<< 3) + ms * (bs - as);
    if (r < 0) r = '0;
    r = r >>> 3;
    return (r > 13'sd255) ? 8'hFF : r[7:0];
  endfunction

  function automatic logic [4:0] chan(input pvtd_col_t c, input int k);
    logic [4:0] v;
    case (k)
      0: v = c.r;
      1: v = c.g;
      2: v = c.b;
      default: v = {1'b0, c.a};
    endcase
    return v;
  endfunction

  logic [2:0] u;
  logic [1:0] v;

  // Stage 1: horizontal interpolation
  logic signed [11:0] ta1 [4], ta2 [4], tb1 [4], tb2 [4];
  logic [3:0]         mv1;
  logic               pt1;
  pvtd_ctl_t          ctl1;

  always_comb begin
    u = ctl_in.two ? {~ctl_in.xl[2], ctl_in.xl[1:0]} : {1'b0, ~ctl_in.xl[1], ctl_in.xl[0]};
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 4; k++) begin
      ta1[k] <= lerp_h(chan(col_a[0], k), chan(col_a[1], k), ctl_in.two, u);
      ta2[k] <= lerp_h(chan(col_a[2], k), chan(col_a[3], k), ctl_in.two, u);
      tb1[k] <= lerp_h(chan(col_b[0], k), chan(col_b[1], k), ctl_in.two, u);
      tb2[k] <= lerp_h(chan(col_b[2], k), chan(col_b[3], k), ctl_in.two, u);
    end
    mv1 <= mv;
    pt1 <= pt;
    ctl1.fault <= ctl_in.fault;
    ctl1.two   <= ctl_in.two;
    ctl1.xl    <= ctl_in.xl;
    ctl1.yl    <= ctl_in.yl;
    if (rst) begin
      ctl1.vld <= 1'b0;
    end else begin
      ctl1.vld <= ctl_in.vld;
    end
  end

  // Stage 2: vertical interpolation
  logic [7:0] ca [4], cb [4];
  logic [3:0] mv2;
  logic       pt2;
  pvtd_ctl_t  ctl2;

  always_comb begin
    v = {~ctl1.yl[1], ctl1.yl[0]};
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 4; k++) begin
      ca[k] <= lerp_v(ta1[k], ta2[k], v, ctl1.two, k == 3);
      cb[k] <= lerp_v(tb1[k], tb2[k], v, ctl1.two, k == 3);
    end
    mv2 <= mv1;
    pt2 <= pt1;
    ctl2.fault <= ctl1.fault;
    ctl2.two   <= ctl1.two;
    ctl2.xl    <= ctl1.xl;
    ctl2.yl    <= ctl1.yl;
    if (rst) begin
      ctl2.vld <= 1'b0;
    end else begin
      ctl2.vld <= ctl1.vld;
    end
  end

  // Stage 3: blend and output word
  always_ff @(posedge clk) begin
    if (ctl2.fault) begin
      red   <= '0;
      green <= '0;
      blue  <= '0;
      alpha <= '0;
    end else begin
      red   <= blend(ca[0], cb[0], mv2);
      green <= blend(ca[1], cb[1], mv2);
      blue  <= blend(ca[2], cb[2], mv2);
      alpha <= pt2 ? 8'd0 : blend(ca[3], cb[3], mv2);
    end
    coord_fault <= ctl2.fault;
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctl2.vld;
    end
  end

endmodule

### rtl/pvrtc_texel_decoder_core.sv
// Channel   Direction  Handshake               Payload
// request   in         start (busy is low)     req_type, block_index, block_word,
//                                              texel_x, texel_y
// result    out        done, one cycle         red, green, blue, alpha, coord_fault
// config    in         cfg_we                  cfg_index, cfg_data
//
// One request word per clock. A block write lands in the store at the accept edge.
// A fetch raises done through one register per stage: address (at the accept edge),
// store read, unpack and weight, horizontal, vertical and blend. Reset (rst,
// synchronous) clears the pipeline valid bits and loads the config defaults; the
// store and the data registers hold no reset value. busy stays low: results are
// never held back.
module pvrtc_texel_decoder_core
  import pvtd_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  logic                   req_type,
  input  logic [IDX_BITS-1:0]    block_index,
  input  logic [63:0]            block_word,
  input  logic [COORD_BITS-1:0]  texel_x,
  input  logic [COORD_BITS-1:0]  texel_y,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output logic                   done,
  output logic [7:0]             red,
  output logic [7:0]             green,
  output logic [7:0]             blue,
  output logic [7:0]             alpha,
  output logic                   coord_fault
);

  logic       two_bit_mode, wrap_edges;
  logic [3:0] width_log2, height_log2;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      two_bit_mode <= 1'b0;
      wrap_edges   <= 1'b0;
      width_log2   <= 4'd3;
      height_log2  <= 4'd2;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TWO_BIT: two_bit_mode <= cfg_data[0];
        CFG_WRAP:    wrap_edges   <= cfg_data[0];
        CFG_WIDTH:   width_log2   <= cfg_data;
        CFG_HEIGHT:  height_log2  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  logic                     acc, wr, rd;
  logic [3:0][IDX_BITS-1:0] idx;
  logic [3:0][63:0]         words;
  pvtd_ctl_t                ctl_a, ctl_s, ctl_u;
  pvtd_col_t [3:0]          col_a, col_b;
  logic [3:0]               mv;
  logic                     pt;

  assign acc = start && !busy;
  assign wr  = acc && (req_type == REQ_WRITE);
  assign rd  = acc && (req_type == REQ_FETCH);

  pvtd_addr u_addr (
    .clk, .rst,
    .fetch(rd), .texel_x, .texel_y,
    .two_bit_mode, .wrap_edges, .width_log2, .height_log2,
    .idx, .ctl(ctl_a)
  );

  pvtd_store u_store (
    .clk, .rst,
    .we(wr), .waddr(block_index), .wdata(block_word),
    .raddr(idx), .ctl_in(ctl_a),
    .rdata(words), .ctl(ctl_s)
  );

  pvtd_unpack u_unpack (
    .clk, .rst,
    .words, .ctl_in(ctl_s),
    .col_a, .col_b, .mv, .pt, .ctl(ctl_u)
  );

  pvtd_filter u_filter (
    .clk, .rst,
    .col_a, .col_b, .mv, .pt, .ctl_in(ctl_u),
    .done, .red, .green, .blue, .alpha, .coord_fault
  );

endmodule
